@@ hdl/ortk_pkg.sv @@
package ortk_pkg;

    localparam int KEY_W   = 64;
    localparam int ADDR_W  = 32;
    localparam int STAMP_W = 32;
    localparam int ACT_W   = 2;
    localparam int SLOT_W  = 5;
    localparam int COUNT_W = 6;

    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_WRITE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [ADDR_W-1:0]  addr;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic write;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } ctrl_status_t;

endpackage

@@ hdl/ortk_req_if.sv @@
interface ortk_req_if import ortk_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [KEY_W-1:0]   entry_key;
    logic [ADDR_W-1:0]  client_addr;
    logic [STAMP_W-1:0] now;

    modport source (output valid, action, entry_key, client_addr, now, input ready);
    modport sink   (input valid, action, entry_key, client_addr, now, output ready);
endinterface

@@ hdl/ortk_rsp_if.sv @@
interface ortk_rsp_if import ortk_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               success;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] removed_count;

    modport source (output valid, success, slot, removed_count, input ready);
    modport sink   (input valid, success, slot, removed_count, output ready);
endinterface

@@ hdl/ortk_ctrl.sv @@
module ortk_ctrl import ortk_pkg::*; #(
    parameter int ENTRIES = 32,
    parameter int IW      = 5
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd,
    output logic [IW-1:0] rd_idx
);

    state_t        state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == IW'(ENTRIES - 1))
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:   state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (state_reg == ST_IDLE)
        begin
            idx_next = '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SCAN:   cmd.issue  = 1'b1;
            ST_LAST:   ;
            ST_WRITE:  cmd.write  = 1'b1;
            ST_FINISH: cmd.finish = !status.out_busy;
            default:   ;
        endcase
    end

    assign rd_idx = idx_reg;

endmodule

@@ hdl/ortk_datapath.sv @@
module ortk_datapath import ortk_pkg::*; #(
    parameter int ENTRIES = 32,
    parameter int IW      = 5,
    parameter int CW      = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    input  logic [IW-1:0]      rd_idx,
    output ctrl_status_t       status,
    input  logic [ACT_W-1:0]   in_action,
    input  logic [KEY_W-1:0]   in_key,
    input  logic [ADDR_W-1:0]  in_addr,
    input  logic [STAMP_W-1:0] in_now,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_success,
    output logic [SLOT_W-1:0]  out_slot,
    output logic [COUNT_W-1:0] out_removed
);

    // item registers
    logic [ACT_W-1:0]   action_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [STAMP_W-1:0] now_reg;

    // entry storage; valid bits stand in for the reset clear
    entry_t             entry_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, valid_next;

    // read pipeline
    entry_t             rd_entry_reg;
    logic               rd_ok_reg;
    logic               proc_reg;
    logic [IW-1:0]      proc_idx_reg;

    // scan accumulators
    logic               hit_reg;
    logic [IW-1:0]      hit_idx_reg;
    logic [STAMP_W-1:0] best_stamp_reg;
    logic [IW-1:0]      best_idx_reg;
    logic [CW-1:0]      count_reg;

    // result register
    logic               out_valid_reg;
    logic               success_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [COUNT_W-1:0] removed_reg;

    entry_t cur;
    logic   match;
    logic   pair_nz;
    logic   do_write;
    entry_t wr_entry;

    assign cur      = rd_ok_reg ? rd_entry_reg : '0;
    assign match    = (cur.key == key_reg) && (cur.addr == addr_reg);
    assign pair_nz  = (|key_reg) && (|addr_reg);
    assign do_write = cmd.write && (action_reg == ACT_ADD) && !hit_reg;
    assign wr_entry = '{key: key_reg, addr: addr_reg, stamp: now_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= in_action;
            key_reg    <= in_key;
            addr_reg   <= in_addr;
            now_reg    <= in_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            entry_mem[best_idx_reg] <= wr_entry;
        end
        if (cmd.issue)
        begin
            rd_entry_reg <= entry_mem[rd_idx];
        end
        proc_idx_reg <= rd_idx;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (proc_reg && (action_reg == ACT_REMOVE) && match)
        begin
            valid_next[proc_idx_reg] = 1'b0;
        end
        if (do_write)
        begin
            valid_next[best_idx_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
            proc_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rd_ok_reg <= valid_reg[rd_idx];
            proc_reg  <= cmd.issue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            best_stamp_reg <= '1;
            best_idx_reg   <= '0;
            count_reg      <= '0;
        end
        else if (cmd.load)
        begin
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            best_stamp_reg <= '1;
            best_idx_reg   <= '0;
            count_reg      <= '0;
        end
        else if (proc_reg)
        begin
            // lowest matching index wins
            if (pair_nz && match && !hit_reg)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= proc_idx_reg;
            end
            // oldest stamp, later index on ties
            if (cur.stamp <= best_stamp_reg)
            begin
                best_stamp_reg <= cur.stamp;
                best_idx_reg   <= proc_idx_reg;
            end
            if ((action_reg == ACT_REMOVE) && match)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            success_reg <= 1'b0;
            slot_reg    <= '0;
            removed_reg <= '0;
            unique case (action_reg)
                ACT_LOOKUP:
                begin
                    success_reg <= hit_reg;
                    slot_reg    <= hit_reg ? SLOT_W'(hit_idx_reg) : '0;
                end
                ACT_ADD:
                begin
                    success_reg <= !hit_reg;
                    slot_reg    <= hit_reg ? '0 : SLOT_W'(best_idx_reg);
                end
                ACT_REMOVE:
                begin
                    success_reg <= (count_reg != '0);
                    removed_reg <= COUNT_W'(count_reg);
                end
                default: ;
            endcase
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_success     = success_reg;
    assign out_slot        = slot_reg;
    assign out_removed     = removed_reg;

endmodule

@@ hdl/oldest_replace_key_table_unit.sv @@
// Channel | Dir | Beat contents
// --------+-----+-----------------------------------------------------
// req     | in  | action, entry_key, client_addr, now
// rsp     | out | success, slot, removed_count
//
// One beat on req gives one beat on rsp. The entry memory has a single
// read port, so every op walks all entries, one per cycle, then takes a
// step for the last compare and one for the write-back of an add. The
// result sits in an output register; req is taken only while the
// sequencer is idle. Reset clears the per-entry valid bits at once, so
// the table reads as all zero with no clearing pass.
module oldest_replace_key_table_unit import ortk_pkg::*; #(
    parameter int ENTRIES = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ortk_req_if.sink  req,
    ortk_rsp_if.source rsp
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    ctrl_cmd_t     cmd;
    ctrl_status_t  status;
    logic [IW-1:0] rd_idx;

    // sequencer: scan counter and op phases
    ortk_ctrl #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd),
        .rd_idx   (rd_idx)
    );

    // storage, compare, min-stamp tracking and result register
    ortk_datapath #(
        .ENTRIES (ENTRIES),
        .IW      (IW),
        .CW      (CW)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rd_idx      (rd_idx),
        .status      (status),
        .in_action   (req.action),
        .in_key      (req.entry_key),
        .in_addr     (req.client_addr),
        .in_now      (req.now),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_success (rsp.success),
        .out_slot    (rsp.slot),
        .out_removed (rsp.removed_count)
    );

endmodule
